@@ design/btdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btdc_pkg
// Shared codes and fixed field widths of the bitwise trie depth cache.
// ----------------------------------------------------------------------------
package btdc_pkg;

  localparam int KEY_LEN_W  = 7;
  localparam int TURNS_W    = 8;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 7'd64;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_MIN   = 7'd2;
  localparam logic [COUNT_W-1:0]   COUNT_MAX     = 16'hffff;

  // Register index, taken from the word address of the configuration port.
  localparam logic [0:0] REG_KEY_LENGTH = 1'b0;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_STORED  = 3'd0,
    STATUS_EQUAL   = 3'd1,
    STATUS_SMALLER = 3'd2,
    STATUS_FULL    = 3'd3,
    STATUS_FOUND   = 3'd4,
    STATUS_MISS    = 3'd5
  } status_t;

endpackage

@@ design/btdc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btdc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module btdc_ram #(
  parameter int DATA_W = 17,
  parameter int DEPTH  = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/btdc_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btdc_cfg
// APB-style register port holding the key length.
// ----------------------------------------------------------------------------
module btdc_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [btdc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [btdc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [btdc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [btdc_pkg::KEY_LEN_W-1:0]      key_length
);

  logic [btdc_pkg::KEY_LEN_W-1:0] key_length_r;
  logic [btdc_pkg::KEY_LEN_W-1:0] key_length_nxt;
  logic                           sel_key_length;

  assign sel_key_length = (paddr[btdc_pkg::CFG_ADDR_W-1:2] == btdc_pkg::REG_KEY_LENGTH);

  always_comb begin
    key_length_nxt = key_length_r;
    if (psel && penable && pwrite && sel_key_length) begin
      key_length_nxt = pwdata[btdc_pkg::KEY_LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= btdc_pkg::KEY_LEN_RESET;
    end else begin
      key_length_r <= key_length_nxt;
    end
  end

  assign prdata = sel_key_length ?
                  {{(btdc_pkg::CFG_DATA_W-btdc_pkg::KEY_LEN_W){1'b0}}, key_length_r} : '0;
  assign pready     = 1'b1;
  assign key_length = key_length_r;

endmodule

@@ design/btdc_walk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btdc_walk
// Trie walker: shifts the key out one bit per level and follows one table
// word per cycle, allocating node pairs and updating the leaf.
// ----------------------------------------------------------------------------
module btdc_walk #(
  parameter int TABLE_WORDS = 65536,
  parameter int KEY_BITS    = 64
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic [btdc_pkg::KEY_LEN_W-1:0]                 key_length,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic                                           in_cmd,
  input  logic [KEY_BITS-1:0]                            in_key,
  input  logic [btdc_pkg::TURNS_W-1:0]                   in_turns,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic [btdc_pkg::STATUS_W-1:0]                  out_status,
  output logic [btdc_pkg::TURNS_W-1:0]                   out_found_turns,
  output logic [btdc_pkg::COUNT_W-1:0]                   out_entry_count,
  output logic [$clog2(((((TABLE_WORDS+1)/2*2) < 8) ? 8 :
                         ((TABLE_WORDS+1)/2*2)) + 1)-1:0] out_words_used,
  output logic                                           ram_we,
  output logic [$clog2(((((TABLE_WORDS+1)/2*2) < 8) ? 8 :
                         ((TABLE_WORDS+1)/2*2)))-1:0]     ram_waddr,
  output logic [(($clog2(((((TABLE_WORDS+1)/2*2) < 8) ? 8 :
                   ((TABLE_WORDS+1)/2*2))) > 8) ?
                 $clog2(((((TABLE_WORDS+1)/2*2) < 8) ? 8 :
                   ((TABLE_WORDS+1)/2*2))) : 8):0]        ram_wdata,
  output logic [$clog2(((((TABLE_WORDS+1)/2*2) < 8) ? 8 :
                         ((TABLE_WORDS+1)/2*2)))-1:0]     ram_raddr,
  input  logic [(($clog2(((((TABLE_WORDS+1)/2*2) < 8) ? 8 :
                   ((TABLE_WORDS+1)/2*2))) > 8) ?
                 $clog2(((((TABLE_WORDS+1)/2*2) < 8) ? 8 :
                   ((TABLE_WORDS+1)/2*2))) : 8):0]        ram_rdata
);

  localparam int TBL_EVEN = (TABLE_WORDS + 1) / 2 * 2;
  localparam int TBL_SIZE = (TBL_EVEN < 8) ? 8 : TBL_EVEN;
  localparam int AW       = $clog2(TBL_SIZE);
  localparam int NFW      = $clog2(TBL_SIZE + 1);
  // One bit above any pointer or depth value, so all ones marks an unused word.
  localparam int WW       = ((AW > 8) ? AW : 8) + 1;
  localparam int LVW      = $clog2(KEY_BITS);

  localparam logic [WW-1:0]  UNUSED_MARK = {WW{1'b1}};
  localparam logic [WW-1:0]  TBL_LIM     = WW'(TBL_SIZE);
  localparam logic [NFW-1:0] NF_LIM      = NFW'(TBL_SIZE);
  localparam logic [NFW-1:0] NF_RESET    = NFW'(6);
  localparam logic [NFW-1:0] NF_STEP     = NFW'(2);
  localparam logic [AW-1:0]  CLR_LAST    = AW'(TBL_SIZE - 1);
  localparam logic [WW-1:0]  ROOT_LO     = WW'(2);
  localparam logic [WW-1:0]  ROOT_HI     = WW'(4);
  localparam logic [btdc_pkg::KEY_LEN_W-1:0] KEY_LEN_MAX = btdc_pkg::KEY_LEN_W'(KEY_BITS);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [AW-1:0]                   clr_r, clr_nxt;
  logic [NFW-1:0]                  next_free_r, next_free_nxt;
  logic [btdc_pkg::COUNT_W-1:0]    count_r, count_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [LVW-1:0]                  lvl_r, lvl_nxt;
  logic                            byp_valid_r, byp_valid_nxt;

  logic [WW-1:0]                   byp_data_r, byp_data_nxt;
  logic [KEY_BITS-1:0]             key_r, key_nxt;
  btdc_pkg::cmd_t                  cmd_r, cmd_nxt;
  logic [btdc_pkg::TURNS_W-1:0]    turns_r, turns_nxt;
  logic [AW-1:0]                   cur_r, cur_nxt;
  btdc_pkg::status_t               res_status_r, res_status_nxt;
  logic [btdc_pkg::TURNS_W-1:0]    res_found_r, res_found_nxt;
  logic [btdc_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [btdc_pkg::TURNS_W-1:0]    out_found_r, out_found_nxt;
  logic [btdc_pkg::COUNT_W-1:0]    out_count_r, out_count_nxt;
  logic [NFW-1:0]                  out_words_r, out_words_nxt;

  logic [btdc_pkg::KEY_LEN_W-1:0]  levels;
  logic [WW-1:0]                   rd_word;
  logic                            is_unused;
  logic                            is_last;
  logic                            can_alloc;
  logic [WW-1:0]                   new_pos;
  logic [WW-1:0]                   next_slot;
  logic                            slot_ok;

  always_comb begin
    if (key_length < btdc_pkg::KEY_LEN_MIN) begin
      levels = btdc_pkg::KEY_LEN_MIN;
    end else if (key_length > KEY_LEN_MAX) begin
      levels = KEY_LEN_MAX;
    end else begin
      levels = key_length;
    end
  end

  // A word written in the same cycle that its address is read comes from the bypass.
  assign rd_word   = byp_valid_r ? byp_data_r : ram_rdata;
  assign is_unused = (rd_word == UNUSED_MARK);
  assign is_last   = (lvl_r == '0);
  assign can_alloc = (next_free_r < NF_LIM);
  assign new_pos   = is_unused ? WW'(next_free_r) : rd_word;
  assign next_slot = new_pos + WW'(key_r[0]);
  assign slot_ok   = (next_slot < TBL_LIM);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    next_free_nxt  = next_free_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r;
    lvl_nxt        = lvl_r;
    byp_valid_nxt  = 1'b0;
    byp_data_nxt   = byp_data_r;
    key_nxt        = key_r;
    cmd_nxt        = cmd_r;
    turns_nxt      = turns_r;
    cur_nxt        = cur_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    out_words_nxt  = out_words_r;
    ram_we         = 1'b0;
    ram_waddr      = cur_r;
    ram_wdata      = UNUSED_MARK;
    ram_raddr      = cur_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        if (clr_r == AW'(0)) begin
          ram_wdata = ROOT_LO;
        end else if (clr_r == AW'(1)) begin
          ram_wdata = ROOT_HI;
        end else begin
          ram_wdata = UNUSED_MARK;
        end
        clr_nxt = clr_r + AW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt       = btdc_pkg::cmd_t'(in_cmd);
          turns_nxt     = in_turns;
          key_nxt       = in_key >> 1;
          lvl_nxt       = LVW'(levels - btdc_pkg::KEY_LEN_W'(1));
          ram_raddr     = AW'(in_key[0]);
          cur_nxt       = AW'(in_key[0]);
          res_found_nxt = '0;
          state_nxt     = ST_WALK;
        end
      end

      ST_WALK: begin
        if (is_last) begin
          state_nxt = ST_DONE;
          if (cmd_r == btdc_pkg::CMD_INSERT) begin
            if (is_unused && (count_r < btdc_pkg::COUNT_MAX)) begin
              count_nxt = count_r + btdc_pkg::COUNT_W'(1);
            end
            if (rd_word > WW'(turns_r)) begin
              ram_we         = 1'b1;
              ram_wdata      = WW'(turns_r);
              res_status_nxt = btdc_pkg::STATUS_STORED;
            end else if (rd_word == WW'(turns_r)) begin
              res_status_nxt = btdc_pkg::STATUS_EQUAL;
            end else begin
              res_status_nxt = btdc_pkg::STATUS_SMALLER;
            end
          end else if (is_unused) begin
            res_status_nxt = btdc_pkg::STATUS_MISS;
          end else begin
            res_status_nxt = btdc_pkg::STATUS_FOUND;
            res_found_nxt  = rd_word[btdc_pkg::TURNS_W-1:0];
          end
        end else if (is_unused && (cmd_r == btdc_pkg::CMD_LOOKUP)) begin
          res_status_nxt = btdc_pkg::STATUS_MISS;
          state_nxt      = ST_DONE;
        end else if (is_unused && !can_alloc) begin
          res_status_nxt = btdc_pkg::STATUS_FULL;
          state_nxt      = ST_DONE;
        end else begin
          if (is_unused) begin
            // Hang a fresh node pair off this word.
            ram_we        = 1'b1;
            ram_wdata     = WW'(next_free_r);
            next_free_nxt = next_free_r + NF_STEP;
          end
          if (!slot_ok) begin
            res_status_nxt = (cmd_r == btdc_pkg::CMD_INSERT) ?
                             btdc_pkg::STATUS_FULL : btdc_pkg::STATUS_MISS;
            state_nxt      = ST_DONE;
          end else begin
            ram_raddr     = next_slot[AW-1:0];
            cur_nxt       = next_slot[AW-1:0];
            key_nxt       = key_r >> 1;
            lvl_nxt       = lvl_r - LVW'(1);
            byp_valid_nxt = is_unused && (next_slot[AW-1:0] == cur_r);
            byp_data_nxt  = WW'(next_free_r);
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_count_nxt  = count_r;
          out_words_nxt  = next_free_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      next_free_r <= NF_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      lvl_r       <= '0;
      byp_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      next_free_r <= next_free_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      lvl_r       <= lvl_nxt;
      byp_valid_r <= byp_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r   <= byp_data_nxt;
    key_r        <= key_nxt;
    cmd_r        <= cmd_nxt;
    turns_r      <= turns_nxt;
    cur_r        <= cur_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
    out_words_r  <= out_words_nxt;
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_turns = out_found_r;
  assign out_entry_count = out_count_r;
  assign out_words_used  = out_words_r;

endmodule

@@ design/bitwise_trie_depth_cache_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitwise_trie_depth_cache_top
// Binary trie depth cache: insert or look up a key, one trie level per cycle.
// A request is taken in ST_IDLE; ST_WALK then reads one table word per level
//   (levels = key length clamped to 2..KEY_BITS), and ST_DONE registers the result.
// Requests: one at a time; a new one is taken only once the last result is
//   registered, and a walk that stops early on a miss or a full table ends sooner.
// Reset: rst_n is synchronous; afterwards a clearing pass writes the whole
//   table, TABLE_WORDS rounded up to even and at least 8 words, before a request is taken.
// ----------------------------------------------------------------------------
module bitwise_trie_depth_cache_top #(
  parameter int TABLE_WORDS = 65536,
  parameter int KEY_BITS    = 64
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           cfg_psel,
  input  logic                                           cfg_penable,
  input  logic                                           cfg_pwrite,
  input  logic [btdc_pkg::CFG_ADDR_W-1:0]                cfg_paddr,
  input  logic [btdc_pkg::CFG_DATA_W-1:0]                cfg_pwdata,
  output logic [btdc_pkg::CFG_DATA_W-1:0]                cfg_prdata,
  output logic                                           cfg_pready,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic                                           in_cmd,
  input  logic [KEY_BITS-1:0]                            in_key,
  input  logic [btdc_pkg::TURNS_W-1:0]                   in_turns,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic [btdc_pkg::STATUS_W-1:0]                  out_status,
  output logic [btdc_pkg::TURNS_W-1:0]                   out_found_turns,
  output logic [btdc_pkg::COUNT_W-1:0]                   out_entry_count,
  output logic [$clog2(((((TABLE_WORDS+1)/2*2) < 8) ? 8 :
                         ((TABLE_WORDS+1)/2*2)) + 1)-1:0] out_words_used
);

  localparam int TBL_EVEN = (TABLE_WORDS + 1) / 2 * 2;
  localparam int TBL_SIZE = (TBL_EVEN < 8) ? 8 : TBL_EVEN;
  localparam int AW       = $clog2(TBL_SIZE);
  localparam int WW       = ((AW > 8) ? AW : 8) + 1;

  logic [btdc_pkg::KEY_LEN_W-1:0] key_length;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [WW-1:0]                  ram_wdata;
  logic [AW-1:0]                  ram_raddr;
  logic [WW-1:0]                  ram_rdata;

  btdc_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .key_length (key_length)
  );

  btdc_ram #(
    .DATA_W (WW),
    .DEPTH  (TBL_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  btdc_walk #(
    .TABLE_WORDS (TABLE_WORDS),
    .KEY_BITS    (KEY_BITS)
  ) u_walk (
    .clk             (clk),
    .rst_n           (rst_n),
    .key_length      (key_length),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_key          (in_key),
    .in_turns        (in_turns),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found_turns (out_found_turns),
    .out_entry_count (out_entry_count),
    .out_words_used  (out_words_used),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

endmodule

@@ tb/sv/tb_bitwise_trie_depth_cache_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitwise_trie_depth_cache_top
// Self-checking bench for the trie depth cache. A scoreboard keeps its own
// copy of the trie and computes the status, depth, entry count and words used
// for every accepted request. Directed requests hit the field extremes and
// every status but full. Random phases follow at several key lengths, including
// clamped ones. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
localparam int          TABLE_SIZE  = 65536;
localparam int          KEY_WIDTH   = 64;
localparam int unsigned UNUSED_WORD = 32'hffff_ffff;

typedef struct {
  btdc_pkg::status_t status;
  logic [7:0]        found_turns;
  logic [15:0]       entry_count;
  logic [16:0]       words_used;
} depth_result_t;

class depth_cache_scoreboard;
  int unsigned     trie_copy [TABLE_SIZE];
  int unsigned     alloc_ptr;
  int unsigned     key_count;
  logic [6:0]      key_len;
  depth_result_t   expected_results [$];
  int              errors;
  int              results_checked;
  int              requests;
  int              by_status [6];

  function new();
    foreach (trie_copy[i]) trie_copy[i] = UNUSED_WORD;
    trie_copy[0] = 2;
    trie_copy[1] = 4;
    alloc_ptr    = 6;
    key_count    = 0;
    key_len      = btdc_pkg::KEY_LEN_RESET;
  endfunction

  function void set_key_length(logic [6:0] value);
    key_len = value;
  endfunction

  function int unsigned levels();
    if (key_len < btdc_pkg::KEY_LEN_MIN) return btdc_pkg::KEY_LEN_MIN;
    if (key_len > KEY_WIDTH) return KEY_WIDTH;
    return key_len;
  endfunction

  function btdc_pkg::status_t walk_insert(logic [63:0] key, logic [7:0] turns);
    int unsigned     depth;
    int unsigned     pos;
    longint unsigned slot;
    depth = levels();
    pos   = 0;
    for (int unsigned i = 0; i + 1 < depth; i++) begin
      slot = 64'(pos) + 64'(key[i]);
      if (slot >= TABLE_SIZE) return btdc_pkg::STATUS_FULL;
      if (trie_copy[slot] == UNUSED_WORD) begin
        // Out of pairs: nodes made earlier in this walk are kept.
        if (alloc_ptr >= TABLE_SIZE) return btdc_pkg::STATUS_FULL;
        trie_copy[slot] = alloc_ptr;
        alloc_ptr += 2;
      end
      pos = trie_copy[slot];
    end
    slot = 64'(pos) + 64'(key[depth-1]);
    if (slot >= TABLE_SIZE) return btdc_pkg::STATUS_FULL;
    if (trie_copy[slot] == UNUSED_WORD && key_count < btdc_pkg::COUNT_MAX) key_count++;
    if (trie_copy[slot] > turns) begin
      trie_copy[slot] = turns;
      return btdc_pkg::STATUS_STORED;
    end
    return (trie_copy[slot] == turns) ? btdc_pkg::STATUS_EQUAL : btdc_pkg::STATUS_SMALLER;
  endfunction

  function btdc_pkg::status_t walk_lookup(logic [63:0] key, output logic [7:0] turns);
    int unsigned     depth;
    int unsigned     pos;
    longint unsigned slot;
    depth = levels();
    pos   = 0;
    turns = '0;
    for (int unsigned i = 0; i < depth; i++) begin
      slot = 64'(pos) + 64'(key[i]);
      if (slot >= TABLE_SIZE || trie_copy[slot] == UNUSED_WORD)
        return btdc_pkg::STATUS_MISS;
      pos = trie_copy[slot];
    end
    turns = pos[7:0];
    return btdc_pkg::STATUS_FOUND;
  endfunction

  function void note_request(btdc_pkg::cmd_t cmd, logic [63:0] key, logic [7:0] turns);
    depth_result_t want;
    want.found_turns = '0;
    if (cmd == btdc_pkg::CMD_INSERT) want.status = walk_insert(key, turns);
    else want.status = walk_lookup(key, want.found_turns);
    want.entry_count = key_count[15:0];
    want.words_used  = alloc_ptr[16:0];
    by_status[want.status]++;
    requests++;
    expected_results.push_back(want);
  endfunction

  function void check_result(logic [2:0] status, logic [7:0] found_turns,
                             logic [15:0] entry_count, logic [16:0] words_used);
    depth_result_t want;
    results_checked++;
    if (expected_results.size() == 0) begin
      errors++;
      if (errors <= 10) $display("Result %0d arrived with no request outstanding",
                                 results_checked);
      return;
    end
    want = expected_results.pop_front();
    if (status !== want.status || found_turns !== want.found_turns ||
        entry_count !== want.entry_count || words_used !== want.words_used) begin
      errors++;
      if (errors <= 10)
        $display("Mismatch on result %0d (expected/actual): status %0d/%0d turns %0d/%0d %s",
                 results_checked, want.status, status, want.found_turns, found_turns,
                 $sformatf("entries %0d/%0d words %0d/%0d", want.entry_count,
                           entry_count, want.words_used, words_used));
    end
  endfunction

  function void finish();
    if (expected_results.size() != 0) begin
      errors += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end
  endfunction
endclass

module tb_bitwise_trie_depth_cache_top;

  localparam int IDLE_LIMIT = 200000;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [btdc_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [btdc_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [btdc_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;
  logic                            in_valid;
  logic                            in_ready;
  logic                            in_cmd;
  logic [63:0]                     in_key;
  logic [btdc_pkg::TURNS_W-1:0]    in_turns;
  logic                            out_valid;
  logic                            out_ready;
  logic [btdc_pkg::STATUS_W-1:0]   out_status;
  logic [btdc_pkg::TURNS_W-1:0]    out_found_turns;
  logic [btdc_pkg::COUNT_W-1:0]    out_entry_count;
  logic [16:0]                     out_words_used;

  depth_cache_scoreboard sb;
  int                    issued;
  int                    cfg_writes;
  int                    idle_cycles;
  bit                    quiet;
  logic [63:0]           key_pool [$];
  logic [7:0]            turns_pool [$];

  int phase_len   [8] = '{3, 8, 16, 64, 127, 0, 33, 1};
  int phase_items [8] = '{120, 200, 250, 1000, 150, 80, 200, 60};
  int phase_new   [8] = '{35, 35, 40, 75, 70, 25, 45, 25};

  bitwise_trie_depth_cache_top #(
    .TABLE_WORDS(TABLE_SIZE),
    .KEY_BITS   (KEY_WIDTH)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_key         (in_key),
    .in_turns       (in_turns),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_found_turns(out_found_turns),
    .out_entry_count(out_entry_count),
    .out_words_used (out_words_used)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  // Handshake monitor and watchdog.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_request(btdc_pkg::cmd_t'(in_cmd), in_key, in_turns);
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_status, out_found_turns, out_entry_count, out_words_used);
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before taking each result.
  initial begin
    int stall;
    out_ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        out_ready <= 1'b0;
        do @(posedge clk); while (!out_valid);
        repeat (stall - 1) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!out_ready) begin
        out_ready <= 1'b1;
      end
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send(input btdc_pkg::cmd_t cmd, input logic [63:0] key,
                      input logic [7:0] turns);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_key   <= key;
    in_turns <= turns;
    issued++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.results_checked < issued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_key_length(input logic [6:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {btdc_pkg::REG_KEY_LENGTH, 2'b00};
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_key_length(value);
    cfg_writes++;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic remember(input logic [63:0] key, input logic [7:0] turns);
    int slot;
    if (key_pool.size() < 256) begin
      key_pool.push_back(key);
      turns_pool.push_back(turns);
    end else begin
      slot             = $urandom_range(0, 255);
      key_pool[slot]   = key;
      turns_pool[slot] = turns;
    end
  endtask

  // Mostly new keys and repeats of known keys, so walks reach the leaves;
  // a few lookups of unrelated keys add noise.
  task automatic run_phase(input int items, input int new_pct);
    int          r;
    int          idx;
    logic [63:0] key;
    logic [7:0]  turns;
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(0, 39) == 0) quiet = ~quiet;
      r     = $urandom_range(0, 99);
      idx   = (key_pool.size() == 0) ? 0 : $urandom_range(0, key_pool.size() - 1);
      turns = 8'($urandom_range(0, 255));
      if (r < new_pct || key_pool.size() == 0) begin
        // A flipped bit of a known key shares the trie path up to that bit.
        if (key_pool.size() != 0 && $urandom_range(0, 3) == 0)
          key = key_pool[idx] ^ (64'd1 << $urandom_range(0, 63));
        else
          key = {$urandom, $urandom};
        remember(key, turns);
        send(btdc_pkg::CMD_INSERT, key, turns);
      end else if (r < new_pct + 15) begin
        case ($urandom_range(0, 2))
          0:       turns = turns_pool[idx];
          1:       turns = turns_pool[idx] - 8'd1;
          default: ;
        endcase
        send(btdc_pkg::CMD_INSERT, key_pool[idx], turns);
      end else if (r < new_pct + 20) begin
        send(btdc_pkg::CMD_LOOKUP, {$urandom, $urandom}, turns);
      end else begin
        send(btdc_pkg::CMD_LOOKUP, key_pool[idx], turns);
      end
    end
  endtask

  initial begin
    sb          = new();
    issued      = 0;
    cfg_writes  = 0;
    idle_cycles = 0;
    quiet       = 1'b0;
    rst_n       = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    in_valid    = 1'b0;
    in_cmd      = btdc_pkg::CMD_INSERT;
    in_key      = '0;
    in_turns    = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // The table is cleared after reset before the first request is taken.
    do @(posedge clk); while (!in_ready);

    // Directed: every status but full at full key length, then short and clamped lengths
    // walking over leaves that were written as longer keys.
    send(btdc_pkg::CMD_INSERT, 64'd0, 8'd255);
    send(btdc_pkg::CMD_INSERT, 64'd0, 8'd255);
    send(btdc_pkg::CMD_INSERT, 64'd0, 8'd0);
    send(btdc_pkg::CMD_INSERT, 64'd0, 8'd9);
    send(btdc_pkg::CMD_LOOKUP, 64'd0, 8'd0);
    send(btdc_pkg::CMD_LOOKUP, '1, 8'd255);
    send(btdc_pkg::CMD_INSERT, '1, 8'd128);
    send(btdc_pkg::CMD_LOOKUP, '1, 8'd0);
    send(btdc_pkg::CMD_INSERT, 64'h5555_5555_5555_5555, 8'd1);
    send(btdc_pkg::CMD_LOOKUP, 64'haaaa_aaaa_aaaa_aaaa, 8'd0);
    drain();
    write_key_length(7'd2);
    send(btdc_pkg::CMD_LOOKUP, 64'd0, 8'd0);
    send(btdc_pkg::CMD_INSERT, 64'd3, 8'd255);
    send(btdc_pkg::CMD_INSERT, 64'd2, 8'd0);
    send(btdc_pkg::CMD_LOOKUP, 64'd3, 8'd0);
    drain();
    write_key_length(7'd0);
    send(btdc_pkg::CMD_INSERT, 64'd1, 8'd77);
    send(btdc_pkg::CMD_LOOKUP, 64'd1, 8'd0);
    drain();
    write_key_length(7'd127);
    send(btdc_pkg::CMD_LOOKUP, 64'd0, 8'd0);
    send(btdc_pkg::CMD_INSERT, 64'h8000_0000_0000_0000, 8'd200);
    send(btdc_pkg::CMD_LOOKUP, 64'h8000_0000_0000_0000, 8'd0);
    drain();
    write_key_length(7'd65);
    send(btdc_pkg::CMD_LOOKUP, '1, 8'd0);
    send(btdc_pkg::CMD_INSERT, '1, 8'd127);
    drain();

    foreach (phase_len[p]) begin
      write_key_length(7'(phase_len[p]));
      run_phase(phase_items[p], phase_new[p]);
      drain();
    end

    repeat (66) @(posedge clk);
    sb.finish();
    $display("Ran %0d requests under %0d key length writes; final entries %0d, words used %0d.",
             sb.requests, cfg_writes, sb.key_count, sb.alloc_ptr);
    $display("Statuses seen: stored %0d, equal %0d, smaller %0d, full %0d, found %0d, miss %0d.",
             sb.by_status[btdc_pkg::STATUS_STORED], sb.by_status[btdc_pkg::STATUS_EQUAL],
             sb.by_status[btdc_pkg::STATUS_SMALLER], sb.by_status[btdc_pkg::STATUS_FULL],
             sb.by_status[btdc_pkg::STATUS_FOUND], sb.by_status[btdc_pkg::STATUS_MISS]);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
